// ===== hw/rtl/plvc_pkg.sv =====
// Shared widths, codes, control structs and the CORDIC angle table of the path tracker.
package plvc_pkg;

	localparam int PATH_DEPTH   = 1024;
	localparam int CORDIC_STEPS = 16;

	localparam int IDX_W      = 10;
	localparam int POS_W      = 24;
	localparam int VEL_W      = 16;
	localparam int HDG_W      = 16;
	localparam int LD_W       = 23;
	localparam int GAIN_W     = 16;
	localparam int LIM_W      = 15;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 23;

	localparam int ADDR_W    = (PATH_DEPTH > 1) ? $clog2(PATH_DEPTH) : 1;
	localparam int LEN_W     = $clog2(PATH_DEPTH + 1);
	localparam int DIF_W     = POS_W + 1;
	localparam int D_W       = 2 * DIF_W;
	localparam int L2_W      = 2 * LD_W;
	localparam int CR_W      = DIF_W + 11;
	localparam int ANG_W     = 18;
	localparam int STEP_W    = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
	localparam int CGAIN_W   = 17;
	localparam int GM_W      = CR_W + CGAIN_W;
	localparam int E_W       = CR_W - 1;
	localparam int KM_W      = E_W + GAIN_W + 1;
	localparam int ZM_W      = DIF_W + GAIN_W + 1;
	localparam int V_W       = 30;
	localparam int S_W       = 2 * V_W;
	localparam int SQ_STEPS  = S_W / 2;
	localparam int NRM_W     = V_W;
	localparam int NUM_W     = LIM_W + V_W;
	localparam int DIV_STEPS = NUM_W;
	localparam int Q_W       = LIM_W + 1;
	localparam int CNT_W     = $clog2(PATH_DEPTH + DIV_STEPS + SQ_STEPS + 4);
	localparam int DRAIN     = 3;

	localparam logic signed [CGAIN_W-1:0] CORDIC_GAIN = CGAIN_W'(39797);
	localparam logic signed [ANG_W-1:0]   QUARTER     = ANG_W'(16384);

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_TICK  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOOKAHEAD = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KP_XY     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KP_Z      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_XY    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_Z     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_YAW_RATE  = 3'd6;

	typedef struct packed {
		logic              enable;
		logic [LD_W-1:0]   lookahead;
		logic [GAIN_W-1:0] kp_xy;
		logic [GAIN_W-1:0] kp_z;
		logic [LIM_W-1:0]  max_xy;
		logic [LIM_W-1:0]  max_z;
		logic [VEL_W-1:0]  yaw_rate;
	} cfg_t;

	typedef struct packed {
		logic              load;
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
		logic              scan;
		logic              walk;
		logic              rot_init;
		logic              rot_step;
		logic [STEP_W-1:0] rot_idx;
		logic              gain;
		logic              kmul;
		logic              square;
		logic              sum;
		logic              sqrt_step;
		logic              div_init;
		logic              div_step;
		logic              div_last;
		logic              div_y;
		logic              emit;
	} cmd_t;

	typedef struct packed {
		logic [LEN_W-1:0]  path_len;
		logic [ADDR_W-1:0] best;
		logic              exceed;
	} status_t;

	// atan(2^-i) in 1/65536 turn
	function automatic logic signed [ANG_W-1:0] atan_angle(input int i);
		logic signed [ANG_W-1:0] a;
		case (i)
			0:       a = ANG_W'(8192);
			1:       a = ANG_W'(4836);
			2:       a = ANG_W'(2555);
			3:       a = ANG_W'(1297);
			4:       a = ANG_W'(651);
			5:       a = ANG_W'(326);
			6:       a = ANG_W'(163);
			7:       a = ANG_W'(81);
			8:       a = ANG_W'(41);
			9:       a = ANG_W'(20);
			10:      a = ANG_W'(10);
			11:      a = ANG_W'(5);
			12:      a = ANG_W'(3);
			13:      a = ANG_W'(1);
			14:      a = ANG_W'(1);
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

// ===== hw/rtl/plvc_ctrl.sv =====
// Sequencer of the path tracker: scan, walk, rotate, scale, cap and emit.
module plvc_ctrl
	import plvc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] operation,
	input  logic       enable,
	input  status_t    status,
	output cmd_t       cmd,
	output logic       busy
);

	typedef enum logic [15:0] {
		S_IDLE  = 16'h0001,
		S_SCAN  = 16'h0002,
		S_WALK  = 16'h0004,
		S_FETCH = 16'h0008,
		S_ROTI  = 16'h0010,
		S_ROT   = 16'h0020,
		S_GAIN  = 16'h0040,
		S_KMUL  = 16'h0080,
		S_SQ    = 16'h0100,
		S_SUM   = 16'h0200,
		S_SQRT  = 16'h0400,
		S_DIVXI = 16'h0800,
		S_DIVX  = 16'h1000,
		S_DIVYI = 16'h2000,
		S_DIVY  = 16'h4000,
		S_DONE  = 16'h8000
	} state_t;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [CNT_W-1:0] len_c;
	logic             accept;

	assign len_c  = CNT_W'(status.path_len);
	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);

	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q + CNT_W'(1);
		cmd         = '0;
		cmd.rd_addr = ADDR_W'(cnt_q);
		cmd.rot_idx = cnt_q[STEP_W-1:0];
		case (state_q)
			S_IDLE: begin
				cnt_d    = '0;
				cmd.load = accept;
				if (accept && (operation == OP_TICK) && enable) begin
					state_d = (status.path_len == '0) ? S_DONE : S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan  = 1'b1;
				cmd.rd_en = (cnt_q < len_c);
				// wait for the last compare before reading the winner
				if (cnt_q == len_c + CNT_W'(DRAIN)) begin
					state_d = S_WALK;
					cnt_d   = CNT_W'(status.best) + CNT_W'(1);
				end
			end
			S_WALK: begin
				cmd.walk  = 1'b1;
				cmd.rd_en = (cnt_q < len_c);
				if (cnt_q == len_c + CNT_W'(DRAIN)) begin
					state_d = S_FETCH;
				end
			end
			S_FETCH: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_addr = status.best;
				state_d     = S_ROTI;
			end
			S_ROTI: begin
				cmd.rot_init = 1'b1;
				cnt_d        = '0;
				state_d      = S_ROT;
			end
			S_ROT: begin
				cmd.rot_step = 1'b1;
				if (cnt_q == CNT_W'(CORDIC_STEPS - 1)) begin
					state_d = S_GAIN;
				end
			end
			S_GAIN: begin
				cmd.gain = 1'b1;
				state_d  = S_KMUL;
			end
			S_KMUL: begin
				cmd.kmul = 1'b1;
				state_d  = S_SQ;
			end
			S_SQ: begin
				cmd.square = 1'b1;
				state_d    = S_SUM;
			end
			S_SUM: begin
				cmd.sum = 1'b1;
				cnt_d   = '0;
				state_d = S_SQRT;
			end
			S_SQRT: begin
				if (!status.exceed) begin
					state_d = S_DONE;
				end else begin
					cmd.sqrt_step = 1'b1;
					if (cnt_q == CNT_W'(SQ_STEPS - 1)) begin
						state_d = S_DIVXI;
					end
				end
			end
			S_DIVXI: begin
				cmd.div_init = 1'b1;
				cnt_d        = '0;
				state_d      = S_DIVX;
			end
			S_DIVX: begin
				cmd.div_step = 1'b1;
				cmd.div_last = (cnt_q == CNT_W'(DIV_STEPS - 1));
				if (cmd.div_last) begin
					state_d = S_DIVYI;
				end
			end
			S_DIVYI: begin
				cmd.div_init = 1'b1;
				cmd.div_y    = 1'b1;
				cnt_d        = '0;
				state_d      = S_DIVY;
			end
			S_DIVY: begin
				cmd.div_step = 1'b1;
				cmd.div_y    = 1'b1;
				cmd.div_last = (cnt_q == CNT_W'(DIV_STEPS - 1));
				if (cmd.div_last) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				cmd.emit = 1'b1;
				state_d  = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

// ===== hw/rtl/plvc_dp.sv =====
// Datapath of the path tracker: path memory, distance pipeline, CORDIC, gains, sqrt and divider.
module plvc_dp
	import plvc_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  cmd_t                    cmd,
	input  cfg_t                    cfg,
	input  logic [1:0]              operation,
	input  logic [IDX_W-1:0]        point_index,
	input  logic                    last_point,
	input  logic signed [POS_W-1:0] pos_x,
	input  logic signed [POS_W-1:0] pos_y,
	input  logic signed [POS_W-1:0] pos_z,
	input  logic [HDG_W-1:0]        heading,
	output status_t                 status,
	output logic                    result_valid,
	output logic signed [VEL_W-1:0] vel_x,
	output logic signed [VEL_W-1:0] vel_y,
	output logic signed [VEL_W-1:0] vel_z,
	output logic signed [VEL_W-1:0] vel_yaw,
	output logic [IDX_W-1:0]        target_slot,
	output logic                    path_empty
);

	logic [3*POS_W-1:0] mem [PATH_DEPTH];

	logic [LEN_W-1:0]        len_q;
	logic signed [POS_W-1:0] px_q, py_q, pz_q;
	logic [HDG_W-1:0]        hdg_q;
	logic [L2_W-1:0]         l2_q;
	logic                    wr_en;

	// distance pipeline
	logic [3*POS_W-1:0]      rdata_s1;
	logic [ADDR_W-1:0]       idx_s1, idx_s2, idx_s3;
	logic                    v_s1, v_s2, v_s3;
	logic [D_W-1:0]          sqx_s2, sqy_s2, d_s3;
	logic signed [POS_W-1:0] rx, ry, rz;
	logic signed [DIF_W-1:0] dx, dy, dz;
	logic signed [D_W-1:0]   dxe, dye;

	logic [ADDR_W-1:0] best_q;
	logic [D_W-1:0]    bestd_q;
	logic              first_q, walking_q;

	// rotation and scaling
	logic signed [CR_W-1:0]  ex0, ey0, cx_q, cy_q, xs, ys;
	logic signed [ANG_W-1:0] a0, ca_q, at;
	logic signed [HDG_W-1:0] a16;
	logic signed [DIF_W-1:0] ez_q;
	logic signed [GM_W-1:0]  gx, gy;
	logic signed [E_W-1:0]   ex_q, ey_q;
	logic signed [KM_W-1:0]  kx, ky, kps;
	logic signed [ZM_W-1:0]  kz;
	logic signed [V_W-1:0]   vx_q, vy_q, vz_q, zl;

	// cap on the horizontal norm
	logic [S_W-1:0]     sqx_q, sqy_q, limsq_q, ssum;
	logic [S_W-1:0]     sv_q, sr_q, sb_q, st;
	logic               exceed_q;
	logic signed [V_W-1:0] vsel;
	logic [V_W-1:0]     vabs;
	logic [NUM_W-1:0]   num_q;
	logic [NRM_W-1:0]   rem_q, nrm;
	logic [NRM_W:0]     rem2;
	logic               qbit;
	logic [Q_W-1:0]     quo_q, quo_n;
	logic signed [V_W-1:0] vres;

	assign status.path_len = len_q;
	assign status.best     = best_q;
	assign status.exceed   = exceed_q;

	assign wr_en = cmd.load && (operation == OP_WRITE) && (int'(point_index) < PATH_DEPTH);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[ADDR_W'(point_index)] <= {pos_z, pos_y, pos_x};
		end
		if (cmd.rd_en) begin
			rdata_s1 <= mem[cmd.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (cmd.load) begin
			if (wr_en && last_point) begin
				len_q <= LEN_W'(point_index) + LEN_W'(1);
			end else if (operation == OP_CLEAR) begin
				len_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			px_q  <= pos_x;
			py_q  <= pos_y;
			pz_q  <= pos_z;
			hdg_q <= heading;
			l2_q  <= L2_W'(cfg.lookahead) * L2_W'(cfg.lookahead);
		end
	end

	assign rx  = signed'(rdata_s1[POS_W-1:0]);
	assign ry  = signed'(rdata_s1[2*POS_W-1:POS_W]);
	assign rz  = signed'(rdata_s1[3*POS_W-1:2*POS_W]);
	assign dx  = DIF_W'(rx) - DIF_W'(px_q);
	assign dy  = DIF_W'(ry) - DIF_W'(py_q);
	assign dz  = DIF_W'(rz) - DIF_W'(pz_q);
	assign dxe = D_W'(dx);
	assign dye = D_W'(dy);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= cmd.rd_en;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cmd.rd_addr;
		idx_s2 <= idx_s1;
		idx_s3 <= idx_s2;
		sqx_s2 <= D_W'(dxe * dxe);
		sqy_s2 <= D_W'(dye * dye);
		d_s3   <= sqx_s2 + sqy_s2;
	end

	// nearest point keeps the first of a tie; the walk stops at the first point out of reach
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q    <= '0;
			bestd_q   <= '0;
			first_q   <= 1'b1;
			walking_q <= 1'b1;
		end else if (cmd.load) begin
			first_q   <= 1'b1;
			walking_q <= 1'b1;
		end else if (v_s3 && cmd.scan && (first_q || (d_s3 < bestd_q))) begin
			best_q  <= idx_s3;
			bestd_q <= d_s3;
			first_q <= 1'b0;
		end else if (v_s3 && cmd.walk && walking_q) begin
			if (d_s3 <= D_W'(l2_q)) begin
				best_q <= idx_s3;
			end else begin
				walking_q <= 1'b0;
			end
		end
	end

	assign ex0 = CR_W'(dx) <<< 8;
	assign ey0 = CR_W'(dy) <<< 8;
	assign a16 = signed'(HDG_W'(0) - hdg_q);
	assign a0  = ANG_W'(a16);
	assign xs  = cx_q >>> cmd.rot_idx;
	assign ys  = cy_q >>> cmd.rot_idx;
	assign at  = atan_angle(int'(cmd.rot_idx));

	assign gx  = GM_W'(cx_q) * GM_W'(CORDIC_GAIN) + GM_W'(32768);
	assign gy  = GM_W'(cy_q) * GM_W'(CORDIC_GAIN) + GM_W'(32768);
	assign kps = KM_W'(signed'({1'b0, cfg.kp_xy}));
	assign kx  = KM_W'(ex_q) * kps + KM_W'(1 << 19);
	assign ky  = KM_W'(ey_q) * kps + KM_W'(1 << 19);
	assign kz  = ZM_W'(ez_q) * ZM_W'(signed'({1'b0, cfg.kp_z})) + ZM_W'(1 << 11);
	assign zl  = signed'(V_W'(cfg.max_z));

	always_ff @(posedge clk) begin
		if (cmd.rot_init) begin
			ez_q <= dz;
			// bring the angle into +-quarter turn first
			if (a0 > QUARTER) begin
				cx_q <= -ey0;
				cy_q <= ex0;
				ca_q <= a0 - QUARTER;
			end else if (a0 < -QUARTER) begin
				cx_q <= ey0;
				cy_q <= -ex0;
				ca_q <= a0 + QUARTER;
			end else begin
				cx_q <= ex0;
				cy_q <= ey0;
				ca_q <= a0;
			end
		end else if (cmd.rot_step) begin
			if (ca_q >= 0) begin
				cx_q <= cx_q - ys;
				cy_q <= cy_q + xs;
				ca_q <= ca_q - at;
			end else begin
				cx_q <= cx_q + ys;
				cy_q <= cy_q - xs;
				ca_q <= ca_q + at;
			end
		end
		if (cmd.gain) begin
			ex_q <= E_W'(gx >>> 16);
			ey_q <= E_W'(gy >>> 16);
		end
	end

	assign ssum = sqx_q + sqy_q;
	assign st   = sr_q + sb_q;
	assign vsel = cmd.div_y ? vy_q : vx_q;
	assign vabs = vsel[V_W-1] ? V_W'(-vsel) : V_W'(vsel);
	assign nrm  = sr_q[NRM_W-1:0];
	assign rem2 = {rem_q, num_q[NUM_W-1]};
	assign qbit = (rem2 >= {1'b0, nrm});
	assign quo_n = {quo_q[Q_W-2:0], qbit};
	assign vres = vsel[V_W-1] ? -V_W'(quo_n) : V_W'(quo_n);

	always_ff @(posedge clk) begin
		if (cmd.kmul) begin
			vx_q <= V_W'(kx >>> 20);
			vy_q <= V_W'(ky >>> 20);
			vz_q <= V_W'(kz >>> 12);
		end
		if (cmd.square) begin
			sqx_q   <= S_W'(S_W'(vx_q) * S_W'(vx_q));
			sqy_q   <= S_W'(S_W'(vy_q) * S_W'(vy_q));
			limsq_q <= S_W'(cfg.max_xy) * S_W'(cfg.max_xy);
			if (vz_q > zl) begin
				vz_q <= zl;
			end else if (vz_q < -zl) begin
				vz_q <= -zl;
			end
		end
		if (cmd.sum) begin
			sv_q <= ssum;
			sr_q <= '0;
			sb_q <= S_W'(1) << (S_W - 2);
		end else if (cmd.sqrt_step) begin
			if (sv_q >= st) begin
				sv_q <= sv_q - st;
				sr_q <= (sr_q >> 1) + sb_q;
			end else begin
				sr_q <= sr_q >> 1;
			end
			sb_q <= sb_q >> 2;
		end
		if (cmd.div_init) begin
			num_q <= NUM_W'(cfg.max_xy) * NUM_W'(vabs);
			rem_q <= '0;
			quo_q <= '0;
		end else if (cmd.div_step) begin
			num_q <= num_q << 1;
			rem_q <= qbit ? NRM_W'(rem2 - {1'b0, nrm}) : NRM_W'(rem2);
			quo_q <= quo_n;
			if (cmd.div_last) begin
				if (cmd.div_y) begin
					vy_q <= vres;
				end else begin
					vx_q <= vres;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exceed_q <= 1'b0;
		end else if (cmd.sum) begin
			exceed_q <= (ssum > limsq_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			if (len_q == '0) begin
				vel_x       <= '0;
				vel_y       <= '0;
				vel_z       <= '0;
				vel_yaw     <= '0;
				target_slot <= '0;
				path_empty  <= 1'b1;
			end else begin
				vel_x       <= vx_q[VEL_W-1:0];
				vel_y       <= vy_q[VEL_W-1:0];
				vel_z       <= vz_q[VEL_W-1:0];
				vel_yaw     <= signed'(cfg.yaw_rate);
				target_slot <= IDX_W'(best_q);
				path_empty  <= 1'b0;
			end
		end
	end

endmodule

// ===== hw/rtl/path_lookahead_velocity_controller.sv =====
// Top level of the lookahead path tracker: configuration registers, sequencer and datapath.
//
//  channel   handshake                    payload
//  command   start / busy                 operation, point_index, last_point, pos_*, heading
//  result    result_valid (one cycle)     vel_x, vel_y, vel_z, vel_yaw, target_slot, path_empty
//  config    cfg_we                       cfg_index, cfg_wdata
//
// A point write, a clear, a no-op or a disabled tick leaves the sequencer idle. A tick on a path of n
// points scans all n for the closest point, walks on from it while points stay within the lookahead,
// rotates the offset into the heading frame with the CORDIC, applies the gains, and runs the square root
// and the divisions only above the horizontal cap; both path passes use the single memory read port.
// After reset the path is empty and the registers hold their default values.
// Results are shown for one cycle; the receiver cannot stall them.
module path_lookahead_velocity_controller
	import plvc_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [1:0]                operation,
	input  logic [IDX_W-1:0]          point_index,
	input  logic                      last_point,
	input  logic signed [POS_W-1:0]   pos_x,
	input  logic signed [POS_W-1:0]   pos_y,
	input  logic signed [POS_W-1:0]   pos_z,
	input  logic [HDG_W-1:0]          heading,
	output logic                      result_valid,
	output logic signed [VEL_W-1:0]   vel_x,
	output logic signed [VEL_W-1:0]   vel_y,
	output logic signed [VEL_W-1:0]   vel_z,
	output logic signed [VEL_W-1:0]   vel_yaw,
	output logic [IDX_W-1:0]          target_slot,
	output logic                      path_empty,
	input  logic                      cfg_we,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_wdata
);

	cfg_t    cfg_q;
	cmd_t    cmd;
	status_t status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable    <= 1'b1;
			cfg_q.lookahead <= LD_W'(4096);
			cfg_q.kp_xy     <= GAIN_W'(4096);
			cfg_q.kp_z      <= GAIN_W'(4096);
			cfg_q.max_xy    <= LIM_W'(4096);
			cfg_q.max_z     <= LIM_W'(2048);
			cfg_q.yaw_rate  <= VEL_W'(65536 - 1229);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ENABLE:    cfg_q.enable    <= cfg_wdata[0];
				REG_LOOKAHEAD: cfg_q.lookahead <= cfg_wdata[LD_W-1:0];
				REG_KP_XY:     cfg_q.kp_xy     <= cfg_wdata[GAIN_W-1:0];
				REG_KP_Z:      cfg_q.kp_z      <= cfg_wdata[GAIN_W-1:0];
				REG_MAX_XY:    cfg_q.max_xy    <= cfg_wdata[LIM_W-1:0];
				REG_MAX_Z:     cfg_q.max_z     <= cfg_wdata[LIM_W-1:0];
				REG_YAW_RATE:  cfg_q.yaw_rate  <= cfg_wdata[VEL_W-1:0];
				default: ;
			endcase
		end
	end

	plvc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (operation),
		.enable    (cfg_q.enable),
		.status    (status),
		.cmd       (cmd),
		.busy      (busy)
	);

	plvc_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.cfg          (cfg_q),
		.operation    (operation),
		.point_index  (point_index),
		.last_point   (last_point),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z),
		.heading      (heading),
		.status       (status),
		.result_valid (result_valid),
		.vel_x        (vel_x),
		.vel_y        (vel_y),
		.vel_z        (vel_z),
		.vel_yaw      (vel_yaw),
		.target_slot  (target_slot),
		.path_empty   (path_empty)
	);

endmodule

// ===== hw/rtl/plvc_checker.sv =====
// Port-level checks of the path tracker and their binding to the top level.
module plvc_checker
	import plvc_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    start,
	input logic                    busy,
	input logic [1:0]              operation,
	input logic                    result_valid,
	input logic signed [VEL_W-1:0] vel_x,
	input logic signed [VEL_W-1:0] vel_y,
	input logic signed [VEL_W-1:0] vel_z,
	input logic signed [VEL_W-1:0] vel_yaw,
	input logic [IDX_W-1:0]        target_slot,
	input logic                    path_empty
);

	// the result strobe never stays high back to back
	a_strobe_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe held for two cycles");

	// a result never follows an accepted item in the very next cycle
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> !result_valid)
		else $error("result one cycle after accept");

	// writes, clears and no-ops finish at once
	a_write_no_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (operation == OP_WRITE || operation == OP_CLEAR || operation == OP_NONE))
		|=> !busy)
		else $error("busy after a write or clear");

	// an empty path gives an all-zero result
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && path_empty) |-> (vel_x == '0 && vel_y == '0 && vel_z == '0
		&& vel_yaw == '0 && target_slot == '0))
		else $error("empty path result not zero");

endmodule

bind path_lookahead_velocity_controller plvc_checker u_plvc_checker (.*);
